FILE: rtl/can_trd_pkg.sv
`timescale 1ns / 1ps

package can_trd_pkg;

    localparam logic [2:0] ACT_RX_FORWARD   = 3'd0;
    localparam logic [2:0] ACT_ERR_CONSUMED = 3'd1;
    localparam logic [2:0] ACT_RX_INVALID   = 3'd2;
    localparam logic [2:0] ACT_SENT         = 3'd3;
    localparam logic [2:0] ACT_DROPPED      = 3'd4;
    localparam logic [2:0] ACT_RETRY        = 3'd5;
    localparam logic [2:0] ACT_DISCARDED    = 3'd6;

    localparam logic [1:0] WR_COMPLETE = 2'd0;
    localparam logic [1:0] WR_IF_DOWN  = 2'd1;

    localparam logic [0:0] CMD_RX = 1'b0;

    localparam logic [1:0] CFG_FD_MODE     = 2'd0;
    localparam logic [1:0] CFG_STALE_TMO   = 2'd1;
    localparam logic [1:0] CFG_RETRY_MIN   = 2'd2;
    localparam logic [1:0] CFG_RETRY_MAX   = 2'd3;

    localparam logic [7:0] STAT_RX_PASSIVE = 8'h10;
    localparam logic [7:0] STAT_TX_PASSIVE = 8'h20;
    localparam logic [7:0] STAT_ACTIVE     = 8'h40;

    localparam logic [19:0] RETRY_MIN_RST = 20'd100;
    localparam logic [19:0] RETRY_MAX_RST = 20'd100000;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [31:0] now_us;
        logic [0:0]  rx_size_ok;
        logic [0:0]  rx_is_fd;
        logic [0:0]  is_error_frame;
        logic [0:0]  err_busoff;
        logic [0:0]  err_ctrl;
        logic [0:0]  err_restarted;
        logic [7:0]  ctrl_status;
        logic [0:0]  tx_is_fd;
        logic [1:0]  write_result;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  action;
        logic [0:0]  fd_marked;
        logic [19:0] retry_delay_us;
        logic [0:0]  bus_usable_now;
        logic [0:0]  fire_timer;
        logic [31:0] sent_total;
        logic [31:0] received_total;
        logic [31:0] dropped_total;
    } t_out_word;

    typedef struct packed {
        logic        fd_mode;
        logic [31:0] stale_timeout_us;
        logic [19:0] retry_min_us;
        logic [19:0] retry_max_us;
    } t_cfg;

    typedef struct packed {
        logic        bus_usable;
        logic [19:0] retry_interval;
        logic        stuck;
        logic [31:0] stuck_since;
        logic [31:0] sent_count;
        logic [31:0] received_count;
        logic [31:0] dropped_count;
    } t_state;

endpackage

FILE: rtl/can_trd_decide.sv
`timescale 1ns / 1ps

module can_trd_decide
    import can_trd_pkg::*;
(
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    input  t_state    i_cur,
    output t_state    o_nxt,
    output t_out_word o_res
);

    logic [31:0] since;
    logic [31:0] elapsed;
    logic        stale;
    logic [20:0] doubled;
    logic [19:0] next_interval;
    logic        bus_after_err;

    always_comb begin
        since         = i_cur.stuck ? i_cur.stuck_since : i_word.now_us;
        elapsed       = i_word.now_us - since;
        stale         = (i_cfg.stale_timeout_us != 32'd0) && (elapsed > i_cfg.stale_timeout_us);
        doubled       = {i_cur.retry_interval, 1'b0};
        next_interval = (doubled > {1'b0, i_cfg.retry_max_us}) ? i_cfg.retry_max_us
                                                               : doubled[19:0];

        bus_after_err = i_cur.bus_usable;
        if (i_word.err_busoff) begin
            bus_after_err = 1'b0;
        end
        if (i_word.err_ctrl) begin
            if ((i_word.ctrl_status & (STAT_TX_PASSIVE | STAT_RX_PASSIVE)) != 8'd0) begin
                bus_after_err = 1'b0;
            end else if ((i_word.ctrl_status & STAT_ACTIVE) != 8'd0) begin
                bus_after_err = 1'b1;
            end
        end
        if (i_word.err_restarted) begin
            bus_after_err = 1'b1;
        end

        o_nxt                = i_cur;
        o_res.action         = ACT_RX_INVALID;
        o_res.fd_marked      = 1'b0;
        o_res.retry_delay_us = 20'd0;
        o_res.fire_timer     = 1'b0;

        if (i_word.cmd == CMD_RX) begin
            if (!i_word.rx_size_ok) begin
                o_res.action = ACT_RX_INVALID;
            end else if (i_word.is_error_frame) begin
                o_nxt.bus_usable = bus_after_err;
                o_res.fire_timer = bus_after_err ^ i_cur.bus_usable;
                o_res.action     = ACT_ERR_CONSUMED;
            end else begin
                o_nxt.received_count = i_cur.received_count + 32'd1;
                o_res.fd_marked      = i_word.rx_is_fd;
                o_res.action         = ACT_RX_FORWARD;
            end
        end else begin
            if (!i_cur.bus_usable) begin
                o_nxt.dropped_count = i_cur.dropped_count + 32'd1;
                o_res.action        = ACT_DROPPED;
            end else if (!i_cfg.fd_mode && i_word.tx_is_fd) begin
                o_res.action = ACT_DISCARDED;
            end else if (i_word.write_result == WR_COMPLETE) begin
                o_nxt.sent_count     = i_cur.sent_count + 32'd1;
                o_nxt.retry_interval = i_cfg.retry_min_us;
                o_nxt.stuck          = 1'b0;
                o_res.action         = ACT_SENT;
            end else if (i_word.write_result == WR_IF_DOWN) begin
                o_nxt.dropped_count = i_cur.dropped_count + 32'd1;
                o_res.action        = ACT_DROPPED;
            end else begin
                o_nxt.stuck       = 1'b1;
                o_nxt.stuck_since = since;
                if (stale) begin
                    o_nxt.dropped_count = i_cur.dropped_count + 32'd1;
                    o_res.action        = ACT_DROPPED;
                end else begin
                    o_res.fd_marked      = i_word.tx_is_fd;
                    o_res.retry_delay_us = i_cur.retry_interval;
                    o_nxt.retry_interval = next_interval;
                    o_res.action         = ACT_RETRY;
                end
            end
        end

        o_res.bus_usable_now = o_nxt.bus_usable;
        o_res.sent_total     = o_nxt.sent_count;
        o_res.received_total = o_nxt.received_count;
        o_res.dropped_total  = o_nxt.dropped_count;
    end

endmodule

FILE: rtl/can_tx_retry_drop_policy.sv
`timescale 1ns / 1ps

// channel  | handshake                      | payload
// ---------+--------------------------------+-------------------------------
// in       | i_in_valid  / o_in_stall       | i_in_word  (t_in_word)
// out      | o_out_valid / i_out_stall      | o_out_word (t_out_word)
// cfg      | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// An accepted word passes the input register, then the result register; one word per cycle
// unless the output stalls. The decision logic between the two registers is combinational.
// Synchronous active-low reset clears state and config to defaults.
// A stalled result holds the result register; the input register still takes
// one word while it is empty, then stall propagates back to the input.

module can_tx_retry_drop_policy
    import can_trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_out_word n_out_word;
    logic      out_adv;

    can_trd_decide u_decide (
        .i_word (r_s1_word),
        .i_cfg  (r_cfg),
        .i_cur  (r_state),
        .o_nxt  (n_state),
        .o_res  (n_out_word)
    );

    assign out_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !out_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_s1_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (out_adv && r_s1_valid) begin
            r_out_word <= n_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.bus_usable     <= 1'b1;
            r_state.retry_interval <= RETRY_MIN_RST;
            r_state.stuck          <= 1'b0;
            r_state.stuck_since    <= 32'd0;
            r_state.sent_count     <= 32'd0;
            r_state.received_count <= 32'd0;
            r_state.dropped_count  <= 32'd0;
        end else if (out_adv && r_s1_valid) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fd_mode          <= 1'b0;
            r_cfg.stale_timeout_us <= 32'd0;
            r_cfg.retry_min_us     <= RETRY_MIN_RST;
            r_cfg.retry_max_us     <= RETRY_MAX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FD_MODE:   r_cfg.fd_mode          <= i_cfg_data[0];
                CFG_STALE_TMO: r_cfg.stale_timeout_us <= i_cfg_data;
                CFG_RETRY_MIN: r_cfg.retry_min_us     <= i_cfg_data[19:0];
                CFG_RETRY_MAX: r_cfg.retry_max_us     <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fire_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.fire_timer) |-> (r_out_word.action == ACT_ERR_CONSUMED))
        else $error("timer fire on non-error word");

    a_delay_only_on_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_word.action != ACT_RETRY)) |-> (r_out_word.retry_delay_us == 20'd0))
        else $error("retry delay on non-retry word");

    a_s1_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_adv) |=> (r_s1_valid && $stable(r_s1_word)))
        else $error("input register lost a word under stall");

    a_bus_usable_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_s1_valid) |=> (r_out_word.bus_usable_now == r_state.bus_usable))
        else $error("reported bus flag differs from state");
`endif

endmodule
